/* hw/rtl/wli_pkg.sv */
// ----------------------------------------------------------------------------
// wli_pkg
// Shared widths, codes and types of the windowed leaky integrator.
// ----------------------------------------------------------------------------
package wli_pkg;

    localparam int ACC_W            = 48;
    localparam int GAIN_W           = 16;
    localparam int GAIN_FRAC        = 14;
    localparam int STEP_W           = 16;
    localparam int WLEN_W           = 11;
    localparam int LIMIT_W          = 2;
    localparam int SPAN_W           = ACC_W + 1;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 48;

    localparam int DEF_WINDOW_DEPTH = 1024;
    localparam int DEF_SAMPLE_WIDTH = 16;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd16384;
    localparam logic [STEP_W-1:0]        STEP_RESET = 16'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METHOD      = 4'd0,
        CFG_LIMIT_MODE  = 4'd1,
        CFG_INIT_STATE  = 4'd2,
        CFG_FB_GAIN     = 4'd3,
        CFG_STEP_SIZE   = 4'd4,
        CFG_WINDOW_LEN  = 4'd5,
        CFG_UPPER_BOUND = 4'd6,
        CFG_LOWER_BOUND = 4'd7
    } cfg_idx_t;

    typedef enum logic [LIMIT_W-1:0] {
        LIM_NONE = 2'd0,
        LIM_SAT  = 2'd1,
        LIM_WRAP = 2'd2
    } limit_mode_t;

    // Leak update sequence in the accumulate stage
    typedef enum logic [1:0] {
        PH_MUL,
        PH_ADD,
        PH_FIN
    } leak_phase_t;

    // Configuration as seen by the datapath, limit mode already decoded
    typedef struct packed {
        logic                      method;
        logic                      sat_en;
        logic                      wrap_en;
        logic signed [ACC_W-1:0]   init;
        logic signed [GAIN_W-1:0]  gain;
        logic [STEP_W-1:0]         step;
        logic signed [ACC_W-1:0]   upper;
        logic signed [ACC_W-1:0]   lower;
        logic signed [SPAN_W-1:0]  span;
    } cfg_t;

    typedef struct packed {
        logic rst;
        logic first;
    } item_flags_t;

endpackage

/* hw/rtl/windowed_leaky_integrator.sv */
// ----------------------------------------------------------------------------
// windowed_leaky_integrator
// Running integral of a signed sample stream, leaky or over a moving window.
// ----------------------------------------------------------------------------
// Each input word carries a sample and a restart flag and yields exactly one
// integral word (signed Q32.16), in order. Areas are step_size*sample or the
// trapezoid of the last two samples. With window_len zero the integral leaks
// by feedback_gain each step; otherwise the last window_len areas sit in a
// ring memory and the oldest leaves the sum as the newest enters. Rate: one
// word per clock for windowed, first and restart samples unless the output
// stalls; an ordinary leaky step holds the accumulate stage through the leak
// phases of the 16x48 feedback multiply, two partial products and a sum.
// After window_len is lowered, the next windowed sample waits while the
// single read port of the ring drains the surplus areas. Words pass the
// input, area, accumulate and output registers. The ring needs no clearing
// pass: entries are read only after being written since the last restart.
// Configuration writes are taken at any time but must land while idle.
// ----------------------------------------------------------------------------
module windowed_leaky_integrator import wli_pkg::*; #(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    // sample words in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                           s_reset_active,
    // integral words out
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [ACC_W-1:0]        m_integral
);

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int AREA_W = SAMPLE_WIDTH + STEP_W + 1;

    // Configuration registers
    logic                     method_reg;
    logic [LIMIT_W-1:0]       limit_mode_reg;
    logic signed [ACC_W-1:0]  init_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [WLEN_W-1:0]        wlen_reg;
    logic signed [ACC_W-1:0]  upper_reg;
    logic signed [ACC_W-1:0]  lower_reg;

    // Decoded configuration, registered from the configuration registers
    logic                     sat_en_reg, sat_en_next;
    logic                     wrap_en_reg, wrap_en_next;
    logic signed [SPAN_W-1:0] span_reg;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic                     crossed;
    cfg_t                     cfg;

    // Pipeline links
    logic                     area_valid;
    logic                     area_ready;
    logic signed [AREA_W-1:0] area;
    item_flags_t              area_flags;
    logic                     acc_valid;
    logic signed [ACC_W-1:0]  acc_value;
    logic                     out_space;

    // Output register
    logic                     o_valid_reg;
    logic signed [ACC_W-1:0]  o_integral_reg;

    assign cfg_ready = 1'b1;

    // ---- configuration writes ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg     <= 1'b0;
            limit_mode_reg <= LIM_NONE;
            init_reg       <= '0;
            gain_reg       <= GAIN_RESET;
            step_reg       <= STEP_RESET;
            wlen_reg       <= '0;
            upper_reg      <= '0;
            lower_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_METHOD:      method_reg     <= cfg_data[0];
                CFG_LIMIT_MODE:  limit_mode_reg <= cfg_data[LIMIT_W-1:0];
                CFG_INIT_STATE:  init_reg       <= $signed(cfg_data[ACC_W-1:0]);
                CFG_FB_GAIN:     gain_reg       <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_STEP_SIZE:   step_reg       <= cfg_data[STEP_W-1:0];
                CFG_WINDOW_LEN:  wlen_reg       <= cfg_data[WLEN_W-1:0];
                CFG_UPPER_BOUND: upper_reg      <= $signed(cfg_data[ACC_W-1:0]);
                CFG_LOWER_BOUND: lower_reg      <= $signed(cfg_data[ACC_W-1:0]);
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // ---- decode limit mode and window length ----
    // Crossed bounds turn wrap into saturate; the unused code means no limit.
    assign crossed      = (upper_reg <= lower_reg);
    assign sat_en_next  = (limit_mode_reg == LIM_SAT) ||
                          ((limit_mode_reg == LIM_WRAP) && crossed);
    assign wrap_en_next = (limit_mode_reg == LIM_WRAP) && !crossed;

    // A window longer than the ring acts as the full ring
    always_comb begin
        if (32'(wlen_reg) > WINDOW_DEPTH) begin
            len_next = CNT_W'(WINDOW_DEPTH);
        end else begin
            len_next = CNT_W'(wlen_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_en_reg  <= 1'b0;
            wrap_en_reg <= 1'b0;
            span_reg    <= '0;
            len_reg     <= '0;
        end else begin
            sat_en_reg  <= sat_en_next;
            wrap_en_reg <= wrap_en_next;
            span_reg    <= SPAN_W'(upper_reg) - SPAN_W'(lower_reg);
            len_reg     <= len_next;
        end
    end

    always_comb begin
        cfg.method  = method_reg;
        cfg.sat_en  = sat_en_reg;
        cfg.wrap_en = wrap_en_reg;
        cfg.init    = init_reg;
        cfg.gain    = gain_reg;
        cfg.step    = step_reg;
        cfg.upper   = upper_reg;
        cfg.lower   = lower_reg;
        cfg.span    = span_reg;
    end

    // ---- input register and area multiply ----
    wli_front #(
        .SAMPLE_W (SAMPLE_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_reset_active (s_reset_active),
        .dn_ready       (area_ready),
        .dn_valid       (area_valid),
        .dn_area        (area),
        .dn_flags       (area_flags)
    );

    // ---- accumulate against ring memory ----
    wli_accum #(
        .DEPTH    (WINDOW_DEPTH),
        .SAMPLE_W (SAMPLE_WIDTH),
        .CNT_W    (CNT_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .len       (len_reg),
        .in_valid  (area_valid),
        .in_ready  (area_ready),
        .in_area   (area),
        .in_flags  (area_flags),
        .out_valid (acc_valid),
        .out_ready (out_space),
        .out_value (acc_value)
    );

    // ---- output register: hold the word until taken, refill on the same clock ----
    assign out_space = !o_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (out_space) begin
            o_valid_reg <= acc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_space && acc_valid) begin
            o_integral_reg <= acc_value;
        end
    end

    assign m_valid    = o_valid_reg;
    assign m_integral = o_integral_reg;

endmodule

/* hw/rtl/wli_front.sv */
// ----------------------------------------------------------------------------
// wli_front
// Input register and area multiplier: two pipeline stages that turn a
// sample into its rectangle or trapezoid area.
// ----------------------------------------------------------------------------
module wli_front import wli_pkg::*; #(
    parameter int SAMPLE_W = DEF_SAMPLE_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_reset_active,
    input  logic                       dn_ready,
    output logic                       dn_valid,
    output logic signed [SAMPLE_W+STEP_W:0] dn_area,
    output item_flags_t                dn_flags
);

    localparam int OPND_W = SAMPLE_W + 1;
    localparam int AREA_W = SAMPLE_W + STEP_W + 1;
    localparam int PROD_W = AREA_W + 1;

    logic                       a_valid_reg;
    logic signed [OPND_W-1:0]   a_opnd_reg;
    logic                       a_trap_reg;
    item_flags_t                a_flags_reg;
    logic                       b_valid_reg;
    logic signed [AREA_W-1:0]   b_area_reg;
    item_flags_t                b_flags_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic                       started_reg;

    logic                       b_take;
    logic                       s_fire;
    logic signed [SAMPLE_W-1:0] xp;
    logic signed [OPND_W-1:0]   opnd_next;
    logic signed [PROD_W-1:0]   prod;
    logic signed [AREA_W-1:0]   area_next;

    assign b_take  = !b_valid_reg || dn_ready;
    assign s_ready = !a_valid_reg || b_take;
    assign s_fire  = s_valid && s_ready;

    // first sample pairs with itself in the trapezoid
    assign xp        = started_reg ? prev_reg : s_sample;
    assign opnd_next = cfg.method ? (OPND_W'(xp) + OPND_W'(s_sample)) : OPND_W'(s_sample);

    assign prod      = PROD_W'($signed({1'b0, cfg.step})) * PROD_W'(a_opnd_reg);
    assign area_next = a_trap_reg ? AREA_W'(prod >>> 1) : AREA_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            started_reg <= 1'b0;
            prev_reg    <= '0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (s_fire) begin
                prev_reg    <= s_sample;
                started_reg <= 1'b1;
            end
            if (b_take) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_opnd_reg        <= opnd_next;
            a_trap_reg        <= cfg.method;
            a_flags_reg.rst   <= s_reset_active;
            a_flags_reg.first <= !started_reg;
        end
        if (a_valid_reg && b_take) begin
            b_area_reg  <= area_next;
            b_flags_reg <= a_flags_reg;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_area  = b_area_reg;
    assign dn_flags = b_flags_reg;

endmodule

/* hw/rtl/wli_ring_ram.sv */
// ----------------------------------------------------------------------------
// wli_ring_ram
// Area ring storage: one write port, one registered read port, with
// write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module wli_ring_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 33
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/wli_accum.sv */
// ----------------------------------------------------------------------------
// wli_accum
// Accumulate stage: ring pointers, ring memory, leak multiply, drain of
// surplus areas and the final saturate / limit.
// ----------------------------------------------------------------------------
module wli_accum import wli_pkg::*; #(
    parameter int DEPTH    = DEF_WINDOW_DEPTH,
    parameter int SAMPLE_W = DEF_SAMPLE_WIDTH,
    parameter int CNT_W    = $clog2(DEF_WINDOW_DEPTH + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cfg_t                            cfg,
    input  logic [CNT_W-1:0]                len,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_W+STEP_W:0] in_area,
    input  item_flags_t                     in_flags,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [ACC_W-1:0]         out_value
);

    localparam int AREA_W = SAMPLE_W + STEP_W + 1;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PSUM_W = AREA_W + CNT_W + 1;
    localparam int SUM_W  = (ACC_W + 3 > PSUM_W + 2) ? ACC_W + 3 : PSUM_W + 2;
    localparam int HI_W   = ACC_W / 2;
    localparam int LO_W   = ACC_W - HI_W;
    localparam int PHI_W  = GAIN_W + HI_W;
    localparam int PLO_W  = GAIN_W + LO_W + 1;
    localparam int FULL_W = GAIN_W + ACC_W;
    localparam int LEAK_W = FULL_W - GAIN_FRAC;
    localparam int WRAP_W = SPAN_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Item held in the stage
    logic                      c_valid_reg;
    logic signed [AREA_W-1:0]  c_area_reg;
    item_flags_t               c_flags_reg;
    leak_phase_t               phase_reg, phase_next;

    // Integrator state
    logic signed [ACC_W-1:0]   acc_reg;
    logic [PTR_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [PSUM_W-1:0]  psum_reg, psum_next;

    // Leak multiply pipeline
    logic signed [PHI_W-1:0]   prod_hi_reg;
    logic signed [PLO_W-1:0]   prod_lo_reg;
    logic signed [LEAK_W-1:0]  leak_reg;
    logic signed [FULL_W-1:0]  leak_full;

    logic                      win;
    logic                      plain;
    logic                      leak_item;
    logic                      drain;
    logic                      pop_now;
    logic                      fire;
    logic                      ring_we;
    logic [PTR_W-1:0]          ring_waddr;
    logic [PTR_W-1:0]          head_inc;
    logic [CNT_W:0]            tail_sum;
    logic [AREA_W-1:0]         ring_rdata;
    logic signed [AREA_W-1:0]  pop_area;
    logic signed [SUM_W-1:0]   sum;
    logic signed [ACC_W-1:0]   sum_sat;
    logic signed [ACC_W-1:0]   clamp_hi;
    logic signed [ACC_W-1:0]   clamp_lo;
    logic signed [WRAP_W-1:0]  wrapped;
    logic signed [ACC_W-1:0]   result;

    function automatic logic signed [ACC_W-1:0] sat_wrap(input logic signed [WRAP_W-1:0] v);
        logic [WRAP_W-ACC_W:0] top;
        top = v[WRAP_W-1:ACC_W-1];
        if ((&top) || !(|top)) begin
            return v[ACC_W-1:0];
        end
        return v[WRAP_W-1] ? ACC_MIN : ACC_MAX;
    endfunction

    // ---- item classification ----
    assign win       = (len != '0);
    assign plain     = !c_flags_reg.rst && !c_flags_reg.first;
    assign leak_item = !win && plain;
    assign drain     = c_valid_reg && win && plain && (count_reg > len);
    assign pop_now   = win && plain && (count_reg >= len);

    // ---- phase sequencer ----
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_MUL: begin
                if (c_valid_reg && leak_item) begin
                    phase_next = PH_ADD;
                end
            end
            PH_ADD: begin
                phase_next = PH_FIN;
            end
            PH_FIN: begin
                if (fire) begin
                    phase_next = PH_MUL;
                end
            end
            default: begin
                phase_next = PH_MUL;
            end
        endcase
    end

    always_comb begin
        out_valid = c_valid_reg && !drain && (!leak_item || (phase_reg == PH_FIN));
        fire      = out_valid && out_ready;
        in_ready  = !c_valid_reg || fire;
    end

    // ---- ring addressing ----
    assign head_inc   = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum   = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign ring_waddr = c_flags_reg.rst ? '0 :
                        ((tail_sum >= (CNT_W+1)'(DEPTH)) ? PTR_W'(tail_sum - (CNT_W+1)'(DEPTH))
                                                         : PTR_W'(tail_sum));
    assign ring_we    = fire && win && (c_flags_reg.rst || !c_flags_reg.first);
    assign pop_area   = $signed(ring_rdata);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        psum_next  = psum_reg;
        if (drain) begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
            psum_next  = psum_reg + PSUM_W'(pop_area);
        end else if (fire) begin
            psum_next = '0;
            if (win) begin
                if (!plain) begin
                    head_next  = '0;
                    count_next = c_flags_reg.rst ? CNT_W'(1) : '0;
                end else if (pop_now) begin
                    head_next  = head_inc;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // read the entry that will be oldest next cycle
    wli_ring_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (AREA_W)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (c_area_reg),
        .raddr (head_next),
        .rdata (ring_rdata)
    );

    // ---- new integral ----
    assign leak_full = (FULL_W'(prod_hi_reg) <<< LO_W) + FULL_W'(prod_lo_reg);

    always_comb begin
        logic [SUM_W-ACC_W:0] top;
        if (!win) begin
            if (c_flags_reg.rst) begin
                sum = SUM_W'(c_area_reg);
            end else if (c_flags_reg.first) begin
                sum = SUM_W'(cfg.init);
            end else begin
                sum = SUM_W'(leak_reg) + SUM_W'(c_area_reg);
            end
        end else if (!plain) begin
            sum = c_flags_reg.rst ? SUM_W'(c_area_reg) : SUM_W'(cfg.init);
        end else begin
            sum = SUM_W'(acc_reg) + SUM_W'(c_area_reg) - SUM_W'(psum_reg)
                - (pop_now ? SUM_W'(pop_area) : SUM_W'(0));
        end
        top = sum[SUM_W-1:ACC_W-1];
        if ((&top) || !(|top)) begin
            sum_sat = sum[ACC_W-1:0];
        end else begin
            sum_sat = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
        end
    end

    always_comb begin
        // upper bound first, lower bound last: lower wins when crossed
        clamp_hi = (sum_sat > cfg.upper) ? cfg.upper : sum_sat;
        clamp_lo = (clamp_hi < cfg.lower) ? cfg.lower : clamp_hi;
        if (sum_sat > cfg.upper) begin
            wrapped = WRAP_W'(sum_sat) - WRAP_W'(cfg.span);
        end else if (sum_sat < cfg.lower) begin
            wrapped = WRAP_W'(sum_sat) + WRAP_W'(cfg.span);
        end else begin
            wrapped = WRAP_W'(sum_sat);
        end
        if (cfg.sat_en) begin
            result = clamp_lo;
        end else if (cfg.wrap_en) begin
            result = sat_wrap(wrapped);
        end else begin
            result = sum_sat;
        end
    end

    assign out_value = result;

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            phase_reg   <= PH_MUL;
            acc_reg     <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            psum_reg    <= '0;
        end else begin
            if (in_ready) begin
                c_valid_reg <= in_valid;
            end
            phase_reg <= phase_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            psum_reg  <= psum_next;
            if (fire) begin
                acc_reg <= result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            c_area_reg  <= in_area;
            c_flags_reg <= in_flags;
        end
        // split 16x48 leak product, then sum and floor-shift
        prod_hi_reg <= PHI_W'(cfg.gain) * PHI_W'($signed(acc_reg[ACC_W-1:LO_W]));
        prod_lo_reg <= PLO_W'(cfg.gain) * PLO_W'($signed({1'b0, acc_reg[LO_W-1:0]}));
        leak_reg    <= leak_full[FULL_W-1:GAIN_FRAC];
    end

endmodule

/* hw/rtl/wli_checker.sv */
// ----------------------------------------------------------------------------
// wli_checker
// Port-level checks of the windowed leaky integrator, bound to the top.
// ----------------------------------------------------------------------------
module wli_checker import wli_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [ACC_W-1:0] m_integral
);

    localparam int MAX_INFLIGHT = 4;

    logic [2:0] inflight_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // words taken in but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else if (s_fire && !m_fire) begin
            inflight_reg <= inflight_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_integral))
        else $error("integral word changed or vanished while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 3'd0)
        else $error("integral word without a pending sample");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'(MAX_INFLIGHT))
        else $error("more samples in flight than pipeline stages");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> inflight_reg != 3'd0)
        else $error("input stalled with nothing in flight");

endmodule

bind windowed_leaky_integrator wli_checker u_wli_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_integral (m_integral)
);

/* sim/tb_windowed_leaky_integrator.sv */
// ----------------------------------------------------------------------------
// tb_windowed_leaky_integrator
// Self-checking bench for the windowed leaky integrator.
// ----------------------------------------------------------------------------
// Drives sample words and register writes over valid/ready channels and keeps
// a cycle-free model of the integral: rectangle or trapezoid area, a leaky
// accumulator or a moving window over a ring of areas, then the limit stage.
// Every accepted sample word queues one predicted integral. Every integral
// word taken from the block is checked against the oldest prediction.
// Directed cases cover the first sample, restarts, window edges, gain
// extremes and all limit modes. Random phases reshuffle the registers while
// both sides idle in short random bursts.
// ----------------------------------------------------------------------------
module tb_windowed_leaky_integrator;
    import wli_pkg::*;

    localparam int     LONG_HOLD      = 300;   // receiver hold-off in cycles
    localparam int     WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
    localparam int     END_SETTLE     = 20;
    localparam int     CFG_COUNT      = 8;     // first unused register index
    localparam int     RANDOM_PHASES  = 14;
    localparam int     WANT_DEPTH     = 16;    // predictions in flight, above pipeline depth

    localparam logic signed [ACC_W-1:0] Q_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Q_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;

    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic signed [DEF_SAMPLE_WIDTH-1:0] s_sample  = '0;
    logic                          s_reset_active = 1'b0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [ACC_W-1:0]       m_integral;

    always #1 aclk = ~aclk;

    windowed_leaky_integrator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .s_reset_active (s_reset_active),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_integral     (m_integral)
    );

    // ------------------------------------------------------------------------
    // Integrator model: register copies and state
    // ------------------------------------------------------------------------
    logic                          method_r = 1'b0;
    logic [LIMIT_W-1:0]            limit_r  = LIM_NONE;
    logic signed [ACC_W-1:0]       init_r   = '0;
    logic signed [GAIN_W-1:0]      gain_r   = GAIN_RESET;
    logic [STEP_W-1:0]             step_r   = STEP_RESET;
    logic [WLEN_W-1:0]             wlen_r   = '0;
    logic signed [ACC_W-1:0]       upper_r  = '0;
    logic signed [ACC_W-1:0]       lower_r  = '0;

    longint                        acc_m      = 0;
    logic signed [DEF_SAMPLE_WIDTH-1:0] prev_m = '0;
    bit                            started_m  = 1'b0;
    longint                        area_ring [DEF_WINDOW_DEPTH];
    int                            ring_head  = 0;
    int                            ring_count = 0;

    // Predicted integral words, oldest first, in a circular buffer
    logic signed [ACC_W-1:0]       want_mem [WANT_DEPTH];
    int                            want_wr    = 0;
    int                            want_rd    = 0;
    int                            want_count = 0;

    int                            errors       = 0;
    int                            quiet_cycles = 0;

    // Idle controls
    bit                            src_gaps   = 1'b1;
    bit                            sink_gaps  = 1'b1;
    bit                            hold_req   = 1'b0;
    int                            hold_left  = 0;
    int                            stall_left = 0;

    // Mirror one register write into the model, masked to the register width
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_METHOD:      method_r = d[0];
            CFG_LIMIT_MODE:  limit_r  = d[LIMIT_W-1:0];
            CFG_INIT_STATE:  init_r   = d[ACC_W-1:0];
            CFG_FB_GAIN:     gain_r   = d[GAIN_W-1:0];
            CFG_STEP_SIZE:   step_r   = d[STEP_W-1:0];
            CFG_WINDOW_LEN:  wlen_r   = d[WLEN_W-1:0];
            CFG_UPPER_BOUND: upper_r  = d[ACC_W-1:0];
            CFG_LOWER_BOUND: lower_r  = d[ACC_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic longint clamp48(input longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    // Advance the model by one sample word and return the integral it yields
    function automatic logic signed [ACC_W-1:0] next_integral(
            input logic signed [DEF_SAMPLE_WIDTH-1:0] x, input logic rst);
        longint ts, xv, xp, area, s, hi, lo, gain;
        int     len;
        bit     first;
        first = !started_m;
        ts    = longint'(step_r);
        xv    = x;
        gain  = gain_r;
        hi    = upper_r;
        lo    = lower_r;
        s     = acc_m;
        len   = (wlen_r > DEF_WINDOW_DEPTH) ? DEF_WINDOW_DEPTH : int'(wlen_r);

        // Rectangle area, or trapezoid of previous and current sample
        if (method_r == 1'b0) begin
            area = ts * xv;
        end else begin
            xp   = first ? xv : longint'(prev_m);
            area = (ts * (xp + xv)) >>> 1;
        end

        if (len == 0) begin
            if (rst)
                s = area;
            else if (first)
                s = init_r;
            else
                s = ((gain * s) >>> GAIN_FRAC) + area;
        end else if (first || rst) begin
            // Empty the ring; a restart seeds it with this area
            ring_head  = 0;
            ring_count = 0;
            s          = init_r;
            if (rst) begin
                s = area;
                area_ring[(ring_head + ring_count) % DEF_WINDOW_DEPTH] = area;
                ring_count++;
            end
        end else begin
            s = s + area;
            // Drop every surplus oldest area, all in this one step
            while (ring_count > 0 && ring_count >= len) begin
                s          = s - area_ring[ring_head];
                ring_head  = (ring_head + 1) % DEF_WINDOW_DEPTH;
                ring_count--;
            end
            area_ring[(ring_head + ring_count) % DEF_WINDOW_DEPTH] = area;
            ring_count++;
        end

        s = clamp48(s);
        // Limit stage; crossed bounds turn wrap into saturate
        if (limit_r == LIM_SAT || (limit_r == LIM_WRAP && hi <= lo)) begin
            if (s > hi)
                s = hi;
            if (s < lo)
                s = lo;
        end else if (limit_r == LIM_WRAP) begin
            if (s > hi)
                s = s - (hi - lo);
            else if (s < lo)
                s = s + (hi - lo);
        end
        acc_m     = clamp48(s);
        prev_m    = x;
        started_m = 1'b1;
        return acc_m[ACC_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: predict on each accepted sample, check each integral word
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic signed [ACC_W-1:0] want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (m_valid && m_ready) begin
                if (want_count == 0) begin
                    $error("integral: no word expected, actual %0d", m_integral);
                    errors++;
                end else begin
                    want       = want_mem[want_rd];
                    want_rd    = (want_rd + 1) % WANT_DEPTH;
                    want_count--;
                    if (m_integral !== want) begin
                        $error("integral: expected %0d actual %0d", want, m_integral);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want_mem[want_wr] = next_integral(s_sample, s_reset_active);
                want_wr           = (want_wr + 1) % WANT_DEPTH;
                want_count++;
            end
        end
    end

    // Watchdog: give up after too many cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts plus an on-demand long hold-off
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready    = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one sample word, maybe after a short gap; leave valid high on exit
    task automatic send_word(input logic signed [DEF_SAMPLE_WIDTH-1:0] smp,
                             input logic rst);
        int gap;
        gap = (src_gaps && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_sample       = smp;
        s_reset_active = rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and hold until every predicted integral has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (want_count != 0) @(posedge aclk);
    endtask

    // Write one register; half the time fill the unused upper data bits
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int                    fw;
        logic [CFG_DATA_W-1:0] keep;
        case (idx)
            CFG_METHOD:     fw = 1;
            CFG_LIMIT_MODE: fw = LIMIT_W;
            CFG_FB_GAIN:    fw = GAIN_W;
            CFG_STEP_SIZE:  fw = STEP_W;
            CFG_WINDOW_LEN: fw = WLEN_W;
            default:        fw = CFG_DATA_W;
        endcase
        keep = (fw >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << fw) - 1);
        if ($urandom_range(0, 1) == 1)
            val = (val & keep) | (CFG_DATA_W'({$urandom, $urandom}) & ~keep);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [DEF_SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DEF_SAMPLE_WIDTH-1){1'b1}}};
            1:       return {1'b1, {(DEF_SAMPLE_WIDTH-1){1'b0}}};
            2:       return '0;
            default: return DEF_SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    // Q32.16 level: extremes, zero, or a random value of random magnitude
    function automatic logic [CFG_DATA_W-1:0] pick_level();
        logic signed [ACC_W-1:0] v;
        case ($urandom_range(0, 6))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2:       v = '0;
            default: begin
                v = ACC_W'({$urandom, $urandom});
                v = v >>> $urandom_range(0, 24);
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // First sample of the run: trapezoid with a window, loads initial_state
    // near the top so the next areas hit the 48-bit saturation
    task automatic test_first_sample();
        write_reg(CFG_METHOD, 1'b1);
        write_reg(CFG_WINDOW_LEN, 4);
        write_reg(CFG_INIT_STATE, 48'h7FFF_FFFF_0000);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh0000, 1'b0);
        send_word(16'shFFFF, 1'b0);
        drain_results();
    endtask

    // Shrink the window below its fill, then ask for more than the ring holds
    task automatic test_window_edges();
        write_reg(CFG_WINDOW_LEN, 1);
        send_word(16'sd100, 1'b0);
        send_word(-16'sd100, 1'b0);
        drain_results();
        write_reg(CFG_WINDOW_LEN, {WLEN_W{1'b1}});
        send_word(16'sd5, 1'b1);
        send_word(16'sd7, 1'b0);
        drain_results();
    endtask

    // Leaky mode at both gain extremes, with a restart in between
    task automatic test_leak_gain();
        write_reg(CFG_WINDOW_LEN, 0);
        write_reg(CFG_METHOD, 1'b0);
        write_reg(CFG_FB_GAIN, 16'h8000);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        send_word(16'sd1, 1'b1);
        drain_results();
        write_reg(CFG_FB_GAIN, 16'h7FFF);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b0);
        drain_results();
    endtask

    // Saturate, crossed bounds, wrap, wrap with crossed bounds, unused mode
    task automatic test_limit_modes();
        write_reg(CFG_FB_GAIN, GAIN_RESET);
        write_reg(CFG_LIMIT_MODE, LIM_SAT);
        write_reg(CFG_UPPER_BOUND, CFG_DATA_W'(64'sd65536000));
        write_reg(CFG_LOWER_BOUND, CFG_DATA_W'(-64'sd65536000));
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh8000, 1'b1);
        drain_results();
        // Upper below lower: the lower bound wins
        write_reg(CFG_UPPER_BOUND, CFG_DATA_W'(-64'sd1048576));
        write_reg(CFG_LOWER_BOUND, CFG_DATA_W'(64'sd1048576));
        send_word(16'sd0, 1'b1);
        drain_results();
        write_reg(CFG_LIMIT_MODE, LIM_WRAP);
        write_reg(CFG_UPPER_BOUND, CFG_DATA_W'(64'sd4294967296));
        write_reg(CFG_LOWER_BOUND, CFG_DATA_W'(-64'sd4294967296));
        send_word(16'sh7FFF, 1'b1);
        send_word(16'sh7FFF, 1'b0);
        send_word(16'sh7FFF, 1'b0);
        drain_results();
        // Equal bounds turn wrap into a clamp
        write_reg(CFG_UPPER_BOUND, CFG_DATA_W'(64'sd327680));
        write_reg(CFG_LOWER_BOUND, CFG_DATA_W'(64'sd327680));
        send_word(16'sd100, 1'b1);
        drain_results();
        write_reg(CFG_LIMIT_MODE, {LIMIT_W{1'b1}});
        send_word(16'sh7FFF, 1'b0);
        drain_results();
        write_reg(CFG_STEP_SIZE, 0);
        send_word(16'sh7FFF, 1'b0);
        drain_results();
    endtask

    // Fill the whole ring, then shrink to one so every area leaves at once
    task automatic test_full_window();
        write_reg(CFG_STEP_SIZE, STEP_RESET);
        write_reg(CFG_LIMIT_MODE, LIM_NONE);
        write_reg(CFG_INIT_STATE, 0);
        write_reg(CFG_METHOD, $urandom_range(0, 1));
        write_reg(CFG_WINDOW_LEN, DEF_WINDOW_DEPTH);
        send_word(pick_sample(), 1'b1);
        repeat (DEF_WINDOW_DEPTH + 80) send_word(pick_sample(), 1'b0);
        drain_results();
        write_reg(CFG_WINDOW_LEN, 1);
        repeat (4) send_word(pick_sample(), 1'b0);
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering: the block must fill
    // and stall its input
    task automatic test_backpressure();
        write_reg(CFG_WINDOW_LEN, 0);
        src_gaps = 1'b0;
        send_word(pick_sample(), 1'b0);
        hold_req = 1'b1;
        repeat (80) send_word(pick_sample(), $urandom_range(0, 15) == 0);
        src_gaps = 1'b1;
        drain_results();
    endtask

    // Sender pauses until all results are back, then carries on unchanged
    task automatic test_sender_pause();
        write_reg(CFG_WINDOW_LEN, 6);
        repeat (20) send_word(pick_sample(), 1'b0);
        drain_results();
        repeat (20) send_word(pick_sample(), 1'b0);
        drain_results();
    endtask

    // Fresh random register set, then a burst of random samples
    task automatic run_random_phase(input int n_items);
        logic [CFG_DATA_W-1:0] up, lo, tmp;
        int                    rst_odds;
        drain_results();
        write_reg(CFG_METHOD, $urandom_range(0, 1));
        write_reg(CFG_LIMIT_MODE, $urandom_range(0, 3));
        write_reg(CFG_INIT_STATE, pick_level());
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_FB_GAIN, 16'h8000);
            1:       write_reg(CFG_FB_GAIN, 16'h7FFF);
            2:       write_reg(CFG_FB_GAIN, GAIN_RESET);
            3:       write_reg(CFG_FB_GAIN, $urandom_range(14000, 16383));
            default: write_reg(CFG_FB_GAIN, $urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_STEP_SIZE, 0);
            1:       write_reg(CFG_STEP_SIZE, STEP_RESET);
            default: write_reg(CFG_STEP_SIZE, $urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: write_reg(CFG_WINDOW_LEN, 0);
            3, 4, 5: write_reg(CFG_WINDOW_LEN, $urandom_range(1, 8));
            6, 7:    write_reg(CFG_WINDOW_LEN, $urandom_range(9, 64));
            8:       write_reg(CFG_WINDOW_LEN, DEF_WINDOW_DEPTH);
            default: write_reg(CFG_WINDOW_LEN, $urandom_range(DEF_WINDOW_DEPTH + 1,
                                                              (1 << WLEN_W) - 1));
        endcase
        // Mostly keep upper above lower so wrap gets real use
        up = pick_level();
        lo = pick_level();
        if ($urandom_range(0, 3) != 0 && $signed(up) < $signed(lo)) begin
            tmp = up;
            up  = lo;
            lo  = tmp;
        end
        write_reg(CFG_UPPER_BOUND, up);
        write_reg(CFG_LOWER_BOUND, lo);
        // Unused indexes must leave every register alone
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'(CFG_COUNT + $urandom_range(0, 7)), {$urandom, $urandom});
        rst_odds = ($urandom_range(0, 2) == 0) ? 4 : 40;
        repeat (n_items) send_word(pick_sample(), $urandom_range(0, rst_odds - 1) == 0);
    endtask

    task automatic test_random_phases();
        repeat (RANDOM_PHASES) run_random_phase($urandom_range(30, 70));
    endtask

    // Last stretch: no idling on either side
    task automatic test_no_idle();
        drain_results();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_random_phase(60);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_first_sample();
        test_window_edges();
        test_leak_gain();
        test_limit_modes();
        test_full_window();
        test_backpressure();
        test_sender_pause();
        test_random_phases();
        test_no_idle();

        // Let any stray word show up before the verdict
        repeat (END_SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
